FILE: design/dtq_pkg.sv
// Package for the deadline timer queue.
// Holds the queue sizes, the opcode codes, the result kind codes and the sequencer state type.
package dtq_pkg;

   localparam int NUM_SLOTS = 16;
   localparam int TIME_BITS = 48;

   localparam logic [1:0] OP_ARM    = 2'd0;
   localparam logic [1:0] OP_CANCEL = 2'd1;
   localparam logic [1:0] OP_TICK   = 2'd2;
   localparam logic [1:0] OP_UNUSED = 2'd3;

   localparam logic KIND_STATUS = 1'b0;
   localparam logic KIND_FIRED  = 1'b1;

   localparam int SEQ_BITS = 16;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ARM_SCAN,
      ST_TICK_SCAN,
      ST_TICK_EMIT,
      ST_REARM,
      ST_REARM_WRITE,
      ST_STAT_SCAN,
      ST_STATUS
   } state_type;

endpackage

FILE: design/deadline_timer_queue_top.sv
// Deadline timer queue, top level.
// Depends on dtq_pkg for queue sizes, opcodes, result kinds and the sequencer state type.
//
// The block holds NUM_SLOTS timer slots and serves one request at a time.
// A shared compare unit visits one slot per cycle under a small sequencer, and
// req_stall stays high until the status result of the request has entered the
// output register. After it is accepted, an arm does a scan for the rearm test,
// a scan for the new earliest deadline and the status step; a cancel or an
// unused opcode does the earliest deadline scan and the status step. A tick does
// one scan per removed slot plus one that finds nothing, one step per removed
// slot to report or drop it, one scan plus a write step per repeating slot it
// re-arms plus a final empty scan, then the earliest deadline scan and the status
// step. Reporting a fired slot and the status step wait while the output register
// is held by rsp_stall. Each fired slot is reported as its own result; the status
// result carries last.
module deadline_timer_queue_top (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [1:0]           req_opcode,
   input  logic [3:0]           req_slot,
   input  logic [47:0]          req_deadline,
   input  logic                 req_repeat_req,
   input  logic [31:0]          req_period,
   input  logic                 req_rearm_request,
   input  logic [47:0]          req_now,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic                 rsp_kind,
   output logic [3:0]           rsp_fired_slot,
   output logic                 rsp_rearm,
   output logic                 rsp_next_valid,
   output logic [47:0]          rsp_next_deadline,
   output logic                 rsp_last
);
   import dtq_pkg::*;

   localparam int IDX_BITS = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
   localparam logic [IDX_BITS-1:0] LAST_IDX = IDX_BITS'(NUM_SLOTS - 1);
   localparam logic [TIME_BITS-1:0] TMAX = {TIME_BITS{1'b1}};

   // Slot store.
   logic [TIME_BITS-1:0] dl_mem [NUM_SLOTS];
   logic [31:0]          per_mem [NUM_SLOTS];
   logic [SEQ_BITS-1:0]  ord_mem [NUM_SLOTS];
   logic [NUM_SLOTS-1:0] rep_ff;
   logic [NUM_SLOTS-1:0] pend_ff, pend_in;
   logic [NUM_SLOTS-1:0] canc_ff, canc_in;
   logic [NUM_SLOTS-1:0] taken_ff, taken_in;
   logic [NUM_SLOTS-1:0] fired_ff, fired_in;
   logic [SEQ_BITS-1:0]  seq_ff, seq_in;

   state_type state_ff, state_in;

   // Latched request.
   logic [1:0]           op_ff;
   logic [IDX_BITS-1:0]  slot_ff;
   logic                 slot_ok_ff;
   logic [TIME_BITS-1:0] dl_ff, now_ff;
   logic                 rep_req_ff, rreq_ff;
   logic [31:0]          per_ff;
   logic [SEQ_BITS-1:0]  base_ff;

   // Scan state and result of the shared compare.
   logic [IDX_BITS-1:0]  idx_ff, idx_in;
   logic                 got_ff, got_in;
   logic [IDX_BITS-1:0]  best_ff, best_in;
   logic [TIME_BITS-1:0] bdl_ff, bdl_in;
   logic [SEQ_BITS-1:0]  bage_ff, bage_in;
   logic                 arm_rearm_ff, arm_rearm_in;

   // Output register.
   logic                 ov_ff, ov_in;
   logic                 okind_ff, okind_in;
   logic [IDX_BITS-1:0]  oslot_ff, oslot_in;
   logic                 orearm_ff, orearm_in;
   logic                 onv_ff, onv_in;
   logic [TIME_BITS-1:0] odl_ff, odl_in;
   logic                 olast_ff, olast_in;

   logic [IDX_BITS-1:0]  ci;
   logic [TIME_BITS-1:0] c_dl, c_sum;
   logic [SEQ_BITS-1:0]  c_age;
   logic                 c_before, c_due, c_first;
   logic [TIME_BITS:0]   sum_wide;
   logic                 wr_en;
   logic [IDX_BITS-1:0]  wr_idx;
   logic [TIME_BITS-1:0] wr_dl;
   logic [31:0]          wr_per;
   logic                 wr_rep;
   logic                 out_free;
   logic                 accept;

   // Ages are taken against the arm count at the start of the request, so they
   // stay put while re-arms advance the count.
   assign ci      = idx_ff;
   assign c_dl    = dl_mem[ci];
   assign c_age   = base_ff - ord_mem[ci];
   assign c_first = pend_ff[ci] && !taken_ff[ci];
   assign c_due   = c_dl <= now_ff;
   // Queue order: deadline, then older arm (scan goes up so ties keep lower slot).
   assign c_before = !got_ff || (c_dl < bdl_ff) || ((c_dl == bdl_ff) && (c_age > bage_ff));

   // Saturating re-arm time for the slot chosen for re-arm.
   assign sum_wide = {1'b0, now_ff} + {{(TIME_BITS+1-32){1'b0}}, per_mem[best_ff]};
   assign c_sum    = sum_wide[TIME_BITS] ? TMAX : sum_wide[TIME_BITS-1:0];

   assign out_free  = !ov_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;

   // Sequencer next state and datapath control.
   always_comb begin
      state_in = state_ff;
      idx_in = idx_ff;
      got_in = got_ff;
      best_in = best_ff;
      bdl_in = bdl_ff;
      bage_in = bage_ff;
      arm_rearm_in = arm_rearm_ff;
      pend_in = pend_ff;
      canc_in = canc_ff;
      taken_in = taken_ff;
      fired_in = fired_ff;
      seq_in = seq_ff;
      ov_in = ov_ff && rsp_stall;
      okind_in = okind_ff;
      oslot_in = oslot_ff;
      orearm_in = orearm_ff;
      onv_in = onv_ff;
      odl_in = odl_ff;
      olast_in = olast_ff;
      wr_en = 1'b0;
      wr_idx = ci;
      wr_dl = c_sum;
      wr_per = per_mem[ci];
      wr_rep = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               idx_in = '0;
               got_in = 1'b0;
               taken_in = '0;
               fired_in = '0;
               arm_rearm_in = 1'b0;
               if (req_opcode == OP_ARM && {28'd0, req_slot} < NUM_SLOTS) begin
                  state_in = ST_ARM_SCAN;
               end else if (req_opcode == OP_TICK) begin
                  state_in = ST_TICK_SCAN;
               end else begin
                  if (req_opcode == OP_CANCEL && {28'd0, req_slot} < NUM_SLOTS) begin
                     canc_in[req_slot[IDX_BITS-1:0]] =
                        pend_ff[req_slot[IDX_BITS-1:0]] || canc_ff[req_slot[IDX_BITS-1:0]];
                  end
                  state_in = ST_STAT_SCAN;
               end
            end
         end
         ST_ARM_SCAN, ST_STAT_SCAN: begin
            // Minimum deadline over pending slots.
            if (pend_ff[ci] && (!got_ff || c_dl < bdl_ff)) begin
               got_in = 1'b1;
               bdl_in = c_dl;
            end
            idx_in = idx_ff + 1'b1;
            if (idx_ff == LAST_IDX) begin
               idx_in = '0;
               if (state_ff == ST_ARM_SCAN) begin
                  arm_rearm_in = rreq_ff &&
                     (!got_in || dl_ff < bdl_in);
                  wr_en = 1'b1;
                  wr_idx = slot_ff;
                  wr_dl = dl_ff;
                  wr_per = per_ff;
                  wr_rep = rep_req_ff;
                  pend_in[slot_ff] = 1'b1;
                  canc_in[slot_ff] = 1'b0;
                  seq_in = seq_ff + 1'b1;
                  got_in = 1'b0;
                  state_in = ST_STAT_SCAN;
               end else begin
                  state_in = ST_STATUS;
               end
            end
         end
         ST_TICK_SCAN: begin
            // Find the next expired slot in queue order.
            if (c_first && c_due && c_before) begin
               got_in = 1'b1;
               best_in = ci;
               bdl_in = c_dl;
               bage_in = c_age;
            end
            idx_in = idx_ff + 1'b1;
            if (idx_ff == LAST_IDX) begin
               idx_in = '0;
               state_in = got_in ? ST_TICK_EMIT : ST_REARM;
               if (!got_in) begin
                  pend_in = pend_ff & ~taken_ff;
               end
            end
         end
         ST_TICK_EMIT: begin
            if (canc_ff[best_ff]) begin
               taken_in[best_ff] = 1'b1;
               got_in = 1'b0;
               state_in = ST_TICK_SCAN;
            end else if (out_free) begin
               taken_in[best_ff] = 1'b1;
               fired_in[best_ff] = 1'b1;
               ov_in = 1'b1;
               okind_in = KIND_FIRED;
               oslot_in = best_ff;
               orearm_in = 1'b0;
               onv_in = 1'b0;
               odl_in = '0;
               olast_in = 1'b0;
               got_in = 1'b0;
               state_in = ST_TICK_SCAN;
            end
         end
         ST_REARM: begin
            // Pick the next fired repeating slot in queue order, which is the firing order.
            if (fired_ff[ci] && rep_ff[ci] && c_before) begin
               got_in = 1'b1;
               best_in = ci;
               bdl_in = c_dl;
               bage_in = c_age;
            end
            idx_in = idx_ff + 1'b1;
            if (idx_ff == LAST_IDX) begin
               idx_in = '0;
               state_in = got_in ? ST_REARM_WRITE : ST_STAT_SCAN;
            end
         end
         ST_REARM_WRITE: begin
            // Re-arm the chosen slot at the saturated now + period.
            wr_en = 1'b1;
            wr_idx = best_ff;
            wr_dl = c_sum;
            wr_per = per_mem[best_ff];
            wr_rep = 1'b1;
            pend_in[best_ff] = 1'b1;
            canc_in[best_ff] = 1'b0;
            seq_in = seq_ff + 1'b1;
            fired_in[best_ff] = 1'b0;
            got_in = 1'b0;
            idx_in = '0;
            state_in = ST_REARM;
         end
         ST_STATUS: begin
            if (out_free) begin
               ov_in = 1'b1;
               okind_in = KIND_STATUS;
               oslot_in = '0;
               onv_in = got_ff;
               odl_in = got_ff ? bdl_ff : '0;
               olast_in = 1'b1;
               if (op_ff == OP_TICK) begin
                  orearm_in = got_ff && (bdl_ff >= now_ff);
               end else if (op_ff == OP_ARM && slot_ok_ff) begin
                  orearm_in = arm_rearm_ff;
               end else begin
                  orearm_in = 1'b0;
               end
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         pend_ff <= '0;
         canc_ff <= '0;
         seq_ff <= '0;
         ov_ff <= 1'b0;
         idx_ff <= '0;
         got_ff <= 1'b0;
         taken_ff <= '0;
         fired_ff <= '0;
      end else begin
         state_ff <= state_in;
         pend_ff <= pend_in;
         canc_ff <= canc_in;
         seq_ff <= seq_in;
         ov_ff <= ov_in;
         idx_ff <= idx_in;
         got_ff <= got_in;
         taken_ff <= taken_in;
         fired_ff <= fired_in;
      end
   end

   // Payload registers and slot store writes.
   always_ff @(posedge clock) begin
      best_ff <= best_in;
      bdl_ff <= bdl_in;
      bage_ff <= bage_in;
      arm_rearm_ff <= arm_rearm_in;
      okind_ff <= okind_in;
      oslot_ff <= oslot_in;
      orearm_ff <= orearm_in;
      onv_ff <= onv_in;
      odl_ff <= odl_in;
      olast_ff <= olast_in;
      if (accept) begin
         op_ff <= req_opcode;
         slot_ff <= req_slot[IDX_BITS-1:0];
         slot_ok_ff <= ({28'd0, req_slot} < NUM_SLOTS);
         dl_ff <= req_deadline[TIME_BITS-1:0];
         now_ff <= req_now[TIME_BITS-1:0];
         rep_req_ff <= req_repeat_req;
         rreq_ff <= req_rearm_request;
         per_ff <= req_period;
         base_ff <= seq_ff;
      end
      if (wr_en) begin
         dl_mem[wr_idx] <= wr_dl;
         per_mem[wr_idx] <= wr_per;
         ord_mem[wr_idx] <= seq_ff;
         rep_ff[wr_idx] <= wr_rep;
      end
   end

   assign rsp_valid = ov_ff;
   assign rsp_kind = okind_ff;
   assign rsp_fired_slot = 4'(oslot_ff);
   assign rsp_rearm = orearm_ff;
   assign rsp_next_valid = onv_ff;
   assign rsp_next_deadline = 48'(odl_ff);
   assign rsp_last = olast_ff;

endmodule

FILE: test/dtq_checker.sv
// Checker for the deadline timer queue: watches both channels, predicts results.
// Depends on dtq_pkg for opcode and result kind codes.
module dtq_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [1:0]  req_opcode,
   input  logic [3:0]  req_slot,
   input  logic [47:0] req_deadline,
   input  logic        req_repeat_req,
   input  logic [31:0] req_period,
   input  logic        req_rearm_request,
   input  logic [47:0] req_now,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic        rsp_kind,
   input  logic [3:0]  rsp_fired_slot,
   input  logic        rsp_rearm,
   input  logic        rsp_next_valid,
   input  logic [47:0] rsp_next_deadline,
   input  logic        rsp_last,
   output int          fail_count,
   output int          pending_count
);
   timeunit 1ns;
   timeprecision 1ps;
   import dtq_pkg::*;

   localparam int SLOTS = 16;
   localparam logic [47:0] TIME_MAX = '1;

   typedef struct packed {
      logic        kind;
      logic [3:0]  fired_slot;
      logic        rearm;
      logic        next_valid;
      logic [47:0] next_deadline;
      logic        last;
   } timer_result_type;

   // Shadow copy of the slot store.
   logic [47:0] shadow_deadline [SLOTS];
   logic [31:0] shadow_period [SLOTS];
   logic        shadow_pending [SLOTS];
   logic        shadow_cancelled [SLOTS];
   logic        shadow_repeat [SLOTS];
   logic [15:0] shadow_order [SLOTS];
   logic [15:0] shadow_seq;

   timer_result_type expected_results [$];

   assign pending_count = expected_results.size();

   // True if slot a leaves the queue ahead of slot b.
   function automatic logic goes_first(int a, int b);
      logic [15:0] age_a, age_b;
      age_a = shadow_seq - shadow_order[a];
      age_b = shadow_seq - shadow_order[b];
      if (shadow_deadline[a] != shadow_deadline[b])
         return shadow_deadline[a] < shadow_deadline[b];
      if (age_a != age_b)
         return age_a > age_b;
      return a < b;
   endfunction

   function automatic logic find_earliest(output logic [47:0] dl);
      logic found;
      found = 1'b0;
      dl = '0;
      for (int i = 0; i < SLOTS; i++)
         if (shadow_pending[i] && (!found || shadow_deadline[i] < dl)) begin
            dl = shadow_deadline[i];
            found = 1'b1;
         end
      return found;
   endfunction

   function automatic void store_slot(int s, logic [47:0] dl, logic rep, logic [31:0] per);
      shadow_deadline[s] = dl;
      shadow_period[s] = per;
      shadow_repeat[s] = rep;
      shadow_pending[s] = 1'b1;
      shadow_cancelled[s] = 1'b0;
      shadow_order[s] = shadow_seq;
      shadow_seq = shadow_seq + 16'd1;
   endfunction

   // Work out and queue every result of one accepted request.
   function automatic void predict_request(logic [1:0] op, logic [3:0] s, logic [47:0] dl,
         logic rep, logic [31:0] per, logic rreq, logic [47:0] now);
      logic             any, nv, rearm, got;
      logic [47:0]      e, nd;
      logic             taken [SLOTS];
      int               fired [$];
      int               best;
      logic [48:0]      sum;
      timer_result_type r;
      rearm = 1'b0;
      if (op == OP_ARM) begin
         any = find_earliest(e);
         rearm = rreq && (!any || dl < e);
         store_slot(s, dl, rep, per);
      end else if (op == OP_CANCEL) begin
         if (shadow_pending[s])
            shadow_cancelled[s] = 1'b1;
      end else if (op == OP_TICK) begin
         foreach (taken[i])
            taken[i] = 1'b0;
         forever begin
            got = 1'b0;
            best = 0;
            for (int i = 0; i < SLOTS; i++)
               if (shadow_pending[i] && !taken[i] && shadow_deadline[i] <= now &&
                     (!got || goes_first(i, best))) begin
                  best = i;
                  got = 1'b1;
               end
            if (!got)
               break;
            taken[best] = 1'b1;
            if (!shadow_cancelled[best]) begin
               fired = {fired, best};
               r = '0;
               r.kind = KIND_FIRED;
               r.fired_slot = best[3:0];
               expected_results = {expected_results, r};
            end
         end
         for (int i = 0; i < SLOTS; i++)
            if (taken[i])
               shadow_pending[i] = 1'b0;
         foreach (fired[j])
            if (shadow_repeat[fired[j]]) begin
               sum = {1'b0, now} + {17'd0, shadow_period[fired[j]]};
               store_slot(fired[j], sum[48] ? TIME_MAX : sum[47:0], 1'b1,
                          shadow_period[fired[j]]);
            end
         nv = find_earliest(nd);
         rearm = nv && nd >= now;
      end
      nv = find_earliest(nd);
      r = '0;
      r.kind = KIND_STATUS;
      r.rearm = rearm;
      r.next_valid = nv;
      r.next_deadline = nd;
      r.last = 1'b1;
      expected_results = {expected_results, r};
   endfunction

   // Sample both channels at each edge.
   always @(posedge clock) begin
      timer_result_type want, got_r;
      if (reset) begin
         foreach (shadow_pending[i]) begin
            shadow_pending[i] = 1'b0;
            shadow_cancelled[i] = 1'b0;
         end
         shadow_seq = '0;
         fail_count <= 0;
      end else begin
         if (req_valid && !req_stall)
            predict_request(req_opcode, req_slot, req_deadline, req_repeat_req, req_period,
                            req_rearm_request, req_now);
         if (rsp_valid && !rsp_stall) begin
            got_r = {rsp_kind, rsp_fired_slot, rsp_rearm, rsp_next_valid,
                     rsp_next_deadline, rsp_last};
            if (expected_results.size() == 0) begin
               $display("%0t: unexpected result %h", $time, got_r);
               fail_count <= fail_count + 1;
            end else begin
               want = expected_results.pop_front();
               if (want !== got_r) begin
                  $display("%0t: mismatch expected kind=%0d slot=%0d rearm=%0d nv=%0d dl=%h last=%0d",
                           $time, want.kind, want.fired_slot, want.rearm, want.next_valid,
                           want.next_deadline, want.last);
                  $display("%0t:          actual   kind=%0d slot=%0d rearm=%0d nv=%0d dl=%h last=%0d",
                           $time, got_r.kind, got_r.fired_slot, got_r.rearm,
                           got_r.next_valid, got_r.next_deadline, got_r.last);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
   end
endmodule

FILE: test/tb.sv
// Testbench top for the deadline timer queue: stimulus, stalls and verdict.
// Depends on dtq_pkg, deadline_timer_queue_top and dtq_checker.
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import dtq_pkg::*;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_opcode = '0;
   logic [3:0]  req_slot = '0;
   logic [47:0] req_deadline = '0;
   logic        req_repeat_req = 1'b0;
   logic [31:0] req_period = '0;
   logic        req_rearm_request = 1'b0;
   logic [47:0] req_now = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_kind;
   logic [3:0]  rsp_fired_slot;
   logic        rsp_rearm;
   logic        rsp_next_valid;
   logic [47:0] rsp_next_deadline;
   logic        rsp_last;
   int          fail_count;
   int          pending_count;
   int          cycle_count = 0;
   logic        long_hold = 1'b0;
   logic [47:0] sim_clock_ms = 48'd1000;

   localparam int CYCLE_LIMIT = 900000;

   deadline_timer_queue_top dut (.*);

   dtq_checker checker_i (.*);

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Timeout watchdog.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("deadline_timer_queue_top test failed");
         $finish;
      end
   end

   // Receiver stall pattern: stretches of free flow, random stalls, long hold.
   always @(posedge clock) begin
      int mode;
      mode = (cycle_count / 2000) % 3;
      if (long_hold)
         rsp_stall <= 1'b1;
      else if (mode == 0)
         rsp_stall <= 1'b0;
      else if (mode == 1)
         rsp_stall <= ($urandom_range(0, 3) == 0);
      else
         rsp_stall <= ($urandom_range(0, 1) == 0);
   end

   // Long receiver hold-off, counted in cycles.
   initial begin
      wait (cycle_count == 3000);
      @(posedge clock);
      long_hold <= 1'b1;
      repeat (600) @(posedge clock);
      long_hold <= 1'b0;
   end

   // Offer one request and wait until it is taken.
   task automatic send_request(logic [1:0] op, logic [3:0] s, logic [47:0] dl, logic rep,
         logic [31:0] per, logic rreq, logic [47:0] now);
      req_valid <= 1'b1;
      req_opcode <= op;
      req_slot <= s;
      req_deadline <= dl;
      req_repeat_req <= rep;
      req_period <= per;
      req_rearm_request <= rreq;
      req_now <= now;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic idle_cycles(int n);
      req_valid <= 1'b0;
      repeat (n) @(posedge clock);
   endtask

   // Random request shaped around a moving current time.
   task automatic send_random;
      int pick;
      logic [47:0] dl;
      logic [31:0] per;
      pick = $urandom_range(0, 99);
      dl = sim_clock_ms + $urandom_range(0, 60);
      if ($urandom_range(0, 19) == 0)
         dl = 48'({$urandom(), $urandom()});
      per = $urandom_range(0, 40);
      if ($urandom_range(0, 19) == 0)
         per = $urandom();
      if (pick < 45)
         send_request(OP_ARM, 4'($urandom_range(0, 15)), dl, 1'($urandom_range(0, 1)), per,
                      1'($urandom_range(0, 1)), 48'({$urandom(), $urandom()}));
      else if (pick < 60)
         send_request(OP_CANCEL, 4'($urandom_range(0, 15)), 48'({$urandom(), $urandom()}),
                      1'($urandom_range(0, 1)), $urandom(), 1'($urandom_range(0, 1)),
                      48'({$urandom(), $urandom()}));
      else if (pick < 97) begin
         sim_clock_ms = sim_clock_ms + $urandom_range(0, 25);
         send_request(OP_TICK, 4'($urandom()), 48'({$urandom(), $urandom()}),
                      1'($urandom_range(0, 1)), $urandom(), 1'($urandom_range(0, 1)),
                      sim_clock_ms);
      end else
         send_request(OP_UNUSED, 4'($urandom()), 48'({$urandom(), $urandom()}),
                      1'($urandom_range(0, 1)), $urandom(), 1'($urandom_range(0, 1)),
                      48'({$urandom(), $urandom()}));
   endtask

   initial begin
      int burst;
      int sent;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part: empty queue, extremes, ties, cancel, wrap-around sums.
      send_request(OP_TICK, 4'd0, '0, 1'b0, '0, 1'b1, '0);
      send_request(OP_ARM, 4'd0, '1, 1'b1, '1, 1'b1, '0);
      send_request(OP_ARM, 4'd15, 48'd0, 1'b0, '0, 1'b1, '1);
      send_request(OP_ARM, 4'd3, 48'd500, 1'b1, 32'd100, 1'b1, '0);
      send_request(OP_ARM, 4'd4, 48'd500, 1'b0, 32'd7, 1'b0, '0);
      send_request(OP_ARM, 4'd2, 48'd500, 1'b1, 32'd0, 1'b1, '0);
      send_request(OP_CANCEL, 4'd4, '1, 1'b1, '1, 1'b1, '1);
      send_request(OP_CANCEL, 4'd9, '0, 1'b0, '0, 1'b0, '0);
      send_request(OP_ARM, 4'd3, 48'd400, 1'b1, 32'd100, 1'b1, '0);
      send_request(OP_UNUSED, 4'd5, '1, 1'b1, '1, 1'b1, '1);
      send_request(OP_TICK, 4'd0, '0, 1'b0, '0, 1'b0, 48'd500);
      send_request(OP_TICK, 4'd0, '0, 1'b0, '0, 1'b0, 48'd600);
      send_request(OP_ARM, 4'd7, 48'd600, 1'b0, '0, 1'b1, '0);
      send_request(OP_TICK, 4'd0, '0, 1'b0, '0, 1'b0, 48'hFFFF_FFFF_FFF0);
      send_request(OP_TICK, 4'd0, '0, 1'b0, '0, 1'b0, '1);
      send_request(OP_CANCEL, 4'd0, '0, 1'b0, '0, 1'b0, '0);
      send_request(OP_TICK, 4'd0, '0, 1'b0, '0, 1'b0, '1);
      idle_cycles(1);

      // Sender pause until every expected result is in.
      wait (pending_count == 0);
      @(posedge clock);

      // Random part in bursts with gaps.
      sent = 0;
      while (sent < 380) begin
         burst = $urandom_range(1, 12);
         repeat (burst) begin
            send_random();
            sent++;
         end
         if ($urandom_range(0, 2) != 0)
            idle_cycles($urandom_range(1, 40));
      end
      req_valid <= 1'b0;

      wait (pending_count == 0);
      repeat (200) @(posedge clock);
      if (fail_count == 0 && pending_count == 0)
         $display("deadline_timer_queue_top test passed");
      else
         $display("deadline_timer_queue_top test failed");
      $finish;
   end
endmodule
